>>> rtl/core/vfcm_pkg.sv
// Shared types, codes and defaults for the voxel face culling mesher.
// Used by every module of the block but vfcm_ram; depends on nothing.
`timescale 1ns / 1ps

package vfcm_pkg;

  localparam int CHUNK_SIDE_DEF = 16;
  localparam int TYPE_COUNT_DEF = 256;

  localparam int COORD_W  = 4;
  localparam int ID_W     = 8;
  localparam int TILE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int FACE_W   = 3;
  localparam int FACES    = 6;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 32;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_WR_CELL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_TYPE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MESH    = 2'd2;

  // faces in emission order
  localparam logic [FACE_W-1:0] FACE_NX   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_PX   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NZ   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PZ   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NY   = 3'd4;
  localparam logic [FACE_W-1:0] FACE_PY   = 3'd5;
  localparam logic [FACE_W-1:0] FACE_LAST = FACE_PY;

  // read steps of a mesh item: the cell itself, then one per face
  localparam logic [2:0] STEP_SELF = 3'd0;
  localparam logic [2:0] STEP_NX   = 3'd1;
  localparam logic [2:0] STEP_PX   = 3'd2;
  localparam logic [2:0] STEP_NZ   = 3'd3;
  localparam logic [2:0] STEP_PZ   = 3'd4;
  localparam logic [2:0] STEP_NY   = 3'd5;
  localparam logic [2:0] STEP_PY   = 3'd6;
  localparam logic [2:0] STEP_LAST = STEP_PY;

  typedef struct packed {
    logic              cube;
    logic [TILE_W-1:0] top;
    logic [TILE_W-1:0] side;
    logic [TILE_W-1:0] bottom;
  } type_entry_t;

  localparam int TYPE_RESET_ID = 1;
  localparam type_entry_t TYPE_RESET_ENTRY = '{
    cube: 1'b1, top: 8'd98, side: 8'd243, bottom: 8'd242
  };

  typedef struct packed {
    logic               start;
    logic [FACES-1:0]   open;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    type_entry_t        entry;
  } mesh_job_t;

endpackage

>>> rtl/core/vfcm_ram.sv
// Generic single-port RAM with registered read (read before write).
// Depends on nothing.
`timescale 1ns / 1ps

module vfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/vfcm_type_table.sv
// Block-type table: RAM plus per-entry valid bits that supply the reset contents.
// Depends on vfcm_pkg and vfcm_ram.
`timescale 1ns / 1ps

module vfcm_type_table #(
  parameter int TYPE_COUNT = vfcm_pkg::TYPE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [$clog2(TYPE_COUNT)-1:0] addr,
  input  vfcm_pkg::type_entry_t         wdata,
  output vfcm_pkg::type_entry_t         rdata
);

  localparam int TIW = $clog2(TYPE_COUNT);

  logic [TYPE_COUNT-1:0]              valid;
  logic                               valid_q;
  logic [TIW-1:0]                     addr_q;
  logic [$bits(vfcm_pkg::type_entry_t)-1:0] ram_rdata;

  vfcm_ram #(
    .WIDTH ($bits(vfcm_pkg::type_entry_t)),
    .DEPTH (TYPE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= valid[addr];
    addr_q  <= addr;
  end

  // unwritten entries read as their reset contents
  always_comb begin
    if (valid_q) begin
      rdata = vfcm_pkg::type_entry_t'(ram_rdata);
    end else if (addr_q == TIW'(vfcm_pkg::TYPE_RESET_ID)) begin
      rdata = vfcm_pkg::TYPE_RESET_ENTRY;
    end else begin
      rdata = '0;
    end
  end

endmodule

>>> rtl/core/vfcm_seq.sv
// Input sequencer: chunk clear pass, cell and type writes, and the pipelined
// neighbor reads (chunk RAM then type table) that build one mesh job.
// Depends on vfcm_pkg.
`timescale 1ns / 1ps

module vfcm_seq #(
  parameter int CHUNK_SIDE = vfcm_pkg::CHUNK_SIDE_DEF,
  parameter int TYPE_COUNT = vfcm_pkg::TYPE_COUNT_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [vfcm_pkg::S_DATA_W-1:0]               s_tdata,
  input  logic [vfcm_pkg::KIND_W-1:0]                 s_tuser,
  output logic                                        cell_we,
  output logic [$clog2(CHUNK_SIDE*CHUNK_SIDE*CHUNK_SIDE)-1:0] cell_addr,
  output logic [vfcm_pkg::ID_W-1:0]                   cell_wdata,
  input  logic [vfcm_pkg::ID_W-1:0]                   cell_rdata,
  output logic                                        type_we,
  output logic [$clog2(TYPE_COUNT)-1:0]               type_addr,
  output vfcm_pkg::type_entry_t                       type_wdata,
  input  vfcm_pkg::type_entry_t                       type_rdata,
  output vfcm_pkg::mesh_job_t                         job,
  input  logic                                        emit_busy
);

  localparam int CELLS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int TIW   = $clog2(TYPE_COUNT);
  localparam int NW    = $clog2(CHUNK_SIDE + 1) + 1;
  localparam int CW    = vfcm_pkg::COORD_W;

  localparam logic signed [NW-1:0] D_ZERO = '0;
  localparam logic signed [NW-1:0] D_POS  = NW'(1);
  localparam logic signed [NW-1:0] D_NEG  = -D_POS;
  localparam logic signed [NW-1:0] SIDE_S = NW'(CHUNK_SIDE);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] clr_cnt;
  logic [2:0]    rd_step;

  logic       p1_vld, p1_oor;
  logic [2:0] p1_step;
  logic       p2_vld, p2_oor, p2_unk;
  logic [2:0] p2_step;

  logic [CW-1:0]         cx, cy, cz;
  logic                  self_cube;
  vfcm_pkg::type_entry_t self_entry;
  logic [vfcm_pkg::FACES-1:0] open_bits;
  logic                  job_start;

  // input word fields
  logic [vfcm_pkg::KIND_W-1:0] in_kind;
  logic [CW-1:0]               in_x, in_y, in_z;
  logic [vfcm_pkg::ID_W-1:0]   in_id;
  vfcm_pkg::type_entry_t       in_entry;
  logic                        accept, in_chunk, id_ok;

  logic signed [NW-1:0] bx, by, bz, dx, dy, dz, nx, ny, nz;
  logic                 oor;
  logic [AW-1:0]        nb_addr;
  logic                 cube_now;

  assign in_kind         = s_tuser;
  assign in_x            = s_tdata[3:0];
  assign in_y            = s_tdata[7:4];
  assign in_z            = s_tdata[11:8];
  assign in_id           = s_tdata[19:12];
  assign in_entry.cube   = s_tdata[20];
  assign in_entry.top    = s_tdata[28:21];
  assign in_entry.side   = s_tdata[36:29];
  assign in_entry.bottom = s_tdata[44:37];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_chunk = (int'(in_x) < CHUNK_SIDE) && (int'(in_y) < CHUNK_SIDE)
                 && (int'(in_z) < CHUNK_SIDE);
  assign id_ok    = int'(in_id) < TYPE_COUNT;

  // cell coordinate plus direction of the current read step
  always_comb begin
    if (state == S_IDLE) begin
      bx = NW'($signed({1'b0, in_x}));
      by = NW'($signed({1'b0, in_y}));
      bz = NW'($signed({1'b0, in_z}));
    end else begin
      bx = NW'($signed({1'b0, cx}));
      by = NW'($signed({1'b0, cy}));
      bz = NW'($signed({1'b0, cz}));
    end
    dx = D_ZERO;
    dy = D_ZERO;
    dz = D_ZERO;
    if (state != S_IDLE) begin
      case (rd_step)
        vfcm_pkg::STEP_NX: dx = D_NEG;
        vfcm_pkg::STEP_PX: dx = D_POS;
        vfcm_pkg::STEP_NZ: dz = D_NEG;
        vfcm_pkg::STEP_PZ: dz = D_POS;
        vfcm_pkg::STEP_NY: dy = D_NEG;
        vfcm_pkg::STEP_PY: dy = D_POS;
        default: ;
      endcase
    end
    nx = bx + dx;
    ny = by + dy;
    nz = bz + dz;
    oor = nx[NW-1] || ny[NW-1] || nz[NW-1]
       || (nx >= SIDE_S) || (ny >= SIDE_S) || (nz >= SIDE_S);
    nb_addr = AW'((AW'($unsigned(nx)) * AW'(CHUNK_SIDE) + AW'($unsigned(ny)))
                  * AW'(CHUNK_SIDE) + AW'($unsigned(nz)));
  end

  // memory port muxes
  always_comb begin
    cell_wdata = in_id;
    type_wdata = in_entry;
    if (state == S_CLEAR) begin
      cell_we    = 1'b1;
      cell_addr  = clr_cnt;
      cell_wdata = '0;
    end else begin
      cell_we   = accept && (in_kind == vfcm_pkg::KIND_WR_CELL) && in_chunk;
      cell_addr = nb_addr;
    end
    if (state == S_IDLE) begin
      type_we   = accept && (in_kind == vfcm_pkg::KIND_WR_TYPE) && id_ok;
      type_addr = in_id[TIW-1:0];
    end else begin
      type_we   = 1'b0;
      type_addr = cell_rdata[TIW-1:0];
    end
  end

  assign cube_now = type_rdata.cube && !p2_unk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rd_step   <= vfcm_pkg::STEP_SELF;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      job_start <= 1'b0;
    end else begin
      job_start <= 1'b0;
      p1_vld    <= (state == S_READ);
      p2_vld    <= p1_vld;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (in_kind == vfcm_pkg::KIND_MESH) && in_chunk) begin
            state   <= S_READ;
            rd_step <= vfcm_pkg::STEP_SELF;
          end
        end
        S_READ: begin
          rd_step <= rd_step + 3'd1;
          if (rd_step == vfcm_pkg::STEP_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (p2_vld && (p2_step == vfcm_pkg::STEP_LAST)) begin
            if (self_cube) begin
              job_start <= 1'b1;
              state     <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          // hold until the emitter has taken and finished the job
          if (!job_start && !emit_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1_step <= rd_step;
    p1_oor  <= oor;
    p2_step <= p1_step;
    p2_oor  <= p1_oor;
    p2_unk  <= (int'(cell_rdata) >= TYPE_COUNT);
    if (accept) begin
      cx <= in_x;
      cy <= in_y;
      cz <= in_z;
    end
    if (p2_vld) begin
      if (p2_step == vfcm_pkg::STEP_SELF) begin
        self_cube  <= cube_now;
        self_entry <= type_rdata;
      end else begin
        open_bits[3'(p2_step - 3'd1)] <= p2_oor || !cube_now;
      end
    end
  end

  assign job = '{start: job_start, open: open_bits, x: cx, y: cy, z: cz,
                 entry: self_entry};

endmodule

>>> rtl/core/vfcm_emit.sv
// Face emitter: walks the six faces of a mesh job and loads open ones into the
// output register with their tile UV bounds. Depends on vfcm_pkg.
`timescale 1ns / 1ps

module vfcm_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  vfcm_pkg::mesh_job_t           job,
  output logic                          busy,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vfcm_pkg::M_DATA_W-1:0] m_tdata,
  output logic [vfcm_pkg::FACE_W-1:0]   m_tuser,
  output logic                          m_tlast
);

  localparam int FW = vfcm_pkg::FACE_W;

  vfcm_pkg::mesh_job_t job_q;
  logic [FW-1:0]       f;
  logic                advance;
  logic [vfcm_pkg::TILE_W-1:0] tile;
  logic [vfcm_pkg::FACES:0]    above;
  logic                        is_last;

  // skip closed faces at once; an open face waits for room in the output register
  assign advance = !job_q.open[f] || !m_tvalid || m_tready;

  always_comb begin
    case (f)
      vfcm_pkg::FACE_NY: tile = job_q.entry.bottom;
      vfcm_pkg::FACE_PY: tile = job_q.entry.top;
      default:           tile = job_q.entry.side;
    endcase
    above   = {1'b0, job_q.open} & ~((7'd2 << f) - 7'd1);
    is_last = (above == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      f        <= vfcm_pkg::FACE_NX;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (!busy) begin
        f <= vfcm_pkg::FACE_NX;
        if (job.start) begin
          busy <= 1'b1;
        end
      end else if (advance) begin
        if (job_q.open[f]) begin
          m_tvalid <= 1'b1;
        end
        if (f == vfcm_pkg::FACE_LAST) begin
          busy <= 1'b0;
        end else begin
          f <= f + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && job.start) begin
      job_q <= job;
    end
    if (busy && advance && job_q.open[f]) begin
      m_tuser <= f;
      m_tlast <= is_last;
      m_tdata <= {3'd0,
                  {1'b0, tile[7:4]} + 5'd1,
                  tile[3:0] + 4'd1,
                  tile[7:4],
                  tile[3:0],
                  job_q.z, job_q.y, job_q.x};
    end
  end

endmodule

>>> rtl/core/voxel_face_culling_mesher.sv
// Voxel face culling mesher top level: chunk RAM, type table, sequencer, emitter.
// Depends on vfcm_pkg, vfcm_ram, vfcm_type_table, vfcm_seq and vfcm_emit.
`timescale 1ns / 1ps

// After reset the block sweeps the chunk RAM to zero, one cell per cycle,
// over all CHUNK_SIDE^3 cells (4096 at the default size) with s_tready low.
// Cell and type writes are then done as the word is taken. A mesh word issues
// seven chunk reads (the cell and its six neighbors), each followed in the
// next cycle by a type table read; both RAMs are single port, so the reads
// stream one per cycle and the job is built as the type reads return. The
// emitter then walks the six face slots in order, skipping closed faces and
// waiting out any output stall at open ones. The next word is taken once the
// reads are done for an empty cell, or once the emitter finishes for a cube.
// Faces come out in the order -x, +x, -z, +z, -y, +y with tlast on the final
// face of a cell; a cell that is empty or outside the chunk gives no word.
module voxel_face_culling_mesher #(
  parameter int CHUNK_SIDE = vfcm_pkg::CHUNK_SIDE_DEF,
  parameter int TYPE_COUNT = vfcm_pkg::TYPE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pos_x[3:0], pos_y[7:4], pos_z[11:8], block_id[19:12], model_kind[20],
  // top_tile[28:21], side_tile[36:29], bottom_tile[44:37], zero[47:45]
  input  logic [vfcm_pkg::S_DATA_W-1:0] s_tdata,
  // kind[1:0]
  input  logic [vfcm_pkg::KIND_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // cell_x[3:0], cell_y[7:4], cell_z[11:8], u_lo[15:12], v_lo[19:16],
  // u_hi[23:20], v_hi[28:24], zero[31:29]
  output logic [vfcm_pkg::M_DATA_W-1:0] m_tdata,
  // face[2:0]
  output logic [vfcm_pkg::FACE_W-1:0]   m_tuser,
  output logic                          m_tlast
);

  localparam int CELLS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int TIW   = $clog2(TYPE_COUNT);

  logic                        cell_we;
  logic [AW-1:0]               cell_addr;
  logic [vfcm_pkg::ID_W-1:0]   cell_wdata, cell_rdata;
  logic                        type_we;
  logic [TIW-1:0]              type_addr;
  vfcm_pkg::type_entry_t       type_wdata, type_rdata;
  vfcm_pkg::mesh_job_t         job;
  logic                        emit_busy;

  vfcm_ram #(
    .WIDTH (vfcm_pkg::ID_W),
    .DEPTH (CELLS)
  ) u_chunk_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  vfcm_type_table #(
    .TYPE_COUNT (TYPE_COUNT)
  ) u_type_table (
    .clk   (clk),
    .rst   (rst),
    .we    (type_we),
    .addr  (type_addr),
    .wdata (type_wdata),
    .rdata (type_rdata)
  );

  vfcm_seq #(
    .CHUNK_SIDE (CHUNK_SIDE),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cell_we    (cell_we),
    .cell_addr  (cell_addr),
    .cell_wdata (cell_wdata),
    .cell_rdata (cell_rdata),
    .type_we    (type_we),
    .type_addr  (type_addr),
    .type_wdata (type_wdata),
    .type_rdata (type_rdata),
    .job        (job),
    .emit_busy  (emit_busy)
  );

  vfcm_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .busy     (emit_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sv/tb_voxel_face_culling_mesher.sv
// Self-checking bench for the voxel face culling mesher: directed and random words,
// a clocked driver and monitor, and an internal model of the chunk and type table.
// Depends on vfcm_pkg and voxel_face_culling_mesher.
`timescale 1ns / 1ps

module tb_voxel_face_culling_mesher;
  import vfcm_pkg::*;

  localparam int SIDE        = CHUNK_SIDE_DEF;
  localparam int QUIET_LIMIT = 20000;  // covers the clear pass after reset
  localparam int RANDOM_WORDS = 300;

  // kind code with no function: the block must ignore it
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [S_DATA_W-1:0] data;
  } stim_word_t;

  typedef struct {
    logic [FACE_W-1:0] face;
    logic [3:0]        x;
    logic [3:0]        y;
    logic [3:0]        z;
    logic [3:0]        u_lo;
    logic [3:0]        v_lo;
    logic [3:0]        u_hi;
    logic [4:0]        v_hi;
    logic              last;
  } face_rec_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [FACE_W-1:0]   m_tuser;
  logic                m_tlast;

  stim_word_t pending_words[$];
  stim_word_t next_word;
  face_rec_t  faces_due[$];

  logic [ID_W-1:0] chunk_ids [0:SIDE*SIDE*SIDE-1];
  type_entry_t     type_table [0:TYPE_COUNT_DEF-1];

  int words_taken = 0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;

  voxel_face_culling_mesher i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every 64 words the bench switches between calm (no idling) and jittery stretches.
  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (words_taken[6]) return 0;
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic int cell_index(int x, int y, int z);
    return (x * SIDE + y) * SIDE + z;
  endfunction

  function automatic bit neighbour_open(int f, int x, int y, int z);
    int nx, ny, nz;
    nx = x;
    ny = y;
    nz = z;
    case (f)
      FACE_NX: nx = x - 1;
      FACE_PX: nx = x + 1;
      FACE_NZ: nz = z - 1;
      FACE_PZ: nz = z + 1;
      FACE_NY: ny = y - 1;
      default: ny = y + 1;
    endcase
    if (nx < 0 || ny < 0 || nz < 0 || nx >= SIDE || ny >= SIDE || nz >= SIDE) return 1'b1;
    return !type_table[chunk_ids[cell_index(nx, ny, nz)]].cube;
  endfunction

  // Update the chunk and type table for one word and queue the faces it should emit.
  function automatic void apply_word(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] data);
    int x, y, z, f, final_face;
    logic [ID_W-1:0]   id;
    logic [TILE_W-1:0] tile;
    logic [FACES-1:0]  open_mask;
    type_entry_t       self_entry;
    face_rec_t         rec;
    x  = int'(data[3:0]);
    y  = int'(data[7:4]);
    z  = int'(data[11:8]);
    id = data[19:12];
    case (kind)
      KIND_WR_CELL: chunk_ids[cell_index(x, y, z)] = id;
      KIND_WR_TYPE: begin
        type_table[id].cube   = data[20];
        type_table[id].top    = data[28:21];
        type_table[id].side   = data[36:29];
        type_table[id].bottom = data[44:37];
      end
      KIND_MESH: begin
        self_entry = type_table[chunk_ids[cell_index(x, y, z)]];
        if (self_entry.cube) begin
          final_face = -1;
          for (f = 0; f < FACES; f++) begin
            open_mask[f] = neighbour_open(f, x, y, z);
            if (open_mask[f]) final_face = f;
          end
          for (f = 0; f < FACES; f++) begin
            if (open_mask[f]) begin
              if (f == FACE_NY) tile = self_entry.bottom;
              else if (f == FACE_PY) tile = self_entry.top;
              else tile = self_entry.side;
              rec.face = FACE_W'(f);
              rec.x    = 4'(x);
              rec.y    = 4'(y);
              rec.z    = 4'(z);
              rec.u_lo = tile[3:0];
              rec.v_lo = tile[7:4];
              rec.u_hi = tile[3:0] + 4'd1;
              rec.v_hi = {1'b0, tile[7:4]} + 5'd1;
              rec.last = (f == final_face);
              faces_due.push_back(rec);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_word(logic [KIND_W-1:0] kind, int x, int y, int z, int id, int mk,
                           int top, int side, int bottom);
    stim_word_t w;
    w.kind = kind;
    w.data = '0;
    w.data[3:0]   = 4'(x);
    w.data[7:4]   = 4'(y);
    w.data[11:8]  = 4'(z);
    w.data[19:12] = 8'(id);
    w.data[20]    = 1'(mk);
    w.data[28:21] = 8'(top);
    w.data[36:29] = 8'(side);
    w.data[44:37] = 8'(bottom);
    pending_words.push_back(w);
  endtask

  task automatic cell_wr(int x, int y, int z, int id);
    push_word(KIND_WR_CELL, x, y, z, id, 0, 0, 0, 0);
  endtask

  task automatic type_wr(int id, int mk, int top, int side, int bottom);
    push_word(KIND_WR_TYPE, 0, 0, 0, id, mk, top, side, bottom);
  endtask

  task automatic queue_mesh(int x, int y, int z);
    push_word(KIND_MESH, x, y, z, 0, 0, 0, 0, 0);
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic check_face();
    face_rec_t e;
    if (faces_due.size() == 0) begin
      $error("face word with nothing expected: face %0d tdata %h", m_tuser, m_tdata);
      errors++;
    end else begin
      e = faces_due.pop_front();
      check_field("face", int'(e.face), int'(m_tuser));
      check_field("cell_x", int'(e.x), int'(m_tdata[3:0]));
      check_field("cell_y", int'(e.y), int'(m_tdata[7:4]));
      check_field("cell_z", int'(e.z), int'(m_tdata[11:8]));
      check_field("u_lo", int'(e.u_lo), int'(m_tdata[15:12]));
      check_field("v_lo", int'(e.v_lo), int'(m_tdata[19:16]));
      check_field("u_hi", int'(e.u_hi), int'(m_tdata[23:20]));
      check_field("v_hi", int'(e.v_hi), int'(m_tdata[28:24]));
      check_field("last", int'(e.last), int'(m_tlast));
    end
  endtask

  // driver: predict on acceptance, then launch the next word after its gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_word(s_tuser, s_tdata);
        words_taken <= words_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_word.kind;
          s_tdata  <= next_word.data;
          gap_left <= idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted face, stall the output side at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) check_face();
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall_left <= idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // corner coordinates: neighbors are common and every coordinate bit toggles
  function automatic int hot_coord();
    int pick;
    pick = int'($urandom_range(0, 3));
    return (pick < 2) ? pick : 12 + pick;
  endfunction

  initial begin
    int i, r, x, y, z, id;
    for (i = 0; i < SIDE * SIDE * SIDE; i++) chunk_ids[i] = '0;
    for (i = 0; i < TYPE_COUNT_DEF; i++) type_table[i] = '0;
    type_table[1] = '{cube: 1'b1, top: 8'd98, side: 8'd243, bottom: 8'd242};

    // directed part
    queue_mesh(0, 0, 0);                    // empty cell: nothing
    cell_wr(0, 0, 0, 1);
    queue_mesh(0, 0, 0);                    // lone cube at the low corner, default tiles
    cell_wr(15, 15, 15, 1);
    queue_mesh(15, 15, 15);                 // lone cube at the high corner
    cell_wr(1, 0, 0, 1);
    queue_mesh(0, 0, 0);                    // +x culled
    type_wr(2, 1, 255, 15, 0);              // side tile wraps u_hi, top gives v_hi of 16
    cell_wr(0, 1, 0, 2);
    queue_mesh(0, 0, 0);
    queue_mesh(0, 1, 0);
    type_wr(255, 1, 8'ha5, 8'h5a, 8'hf0);
    cell_wr(15, 15, 14, 255);
    queue_mesh(15, 15, 15);                 // -z culled by the highest type id
    push_word(KIND_SPARE, 15, 15, 15, 255, 1, 255, 255, 255);  // unused kind: ignored
    queue_mesh(15, 15, 15);
    type_wr(255, 0, 8'h12, 8'h34, 8'h56);   // turn type 255 empty again
    queue_mesh(15, 15, 14);
    queue_mesh(15, 15, 15);
    type_wr(0, 1, 8'h11, 8'h22, 8'h33);     // empty cells become cubes
    queue_mesh(7, 8, 9);                    // fully enclosed: nothing
    queue_mesh(0, 1, 0);                    // only the faces at the chunk border stay
    type_wr(0, 0, 0, 0, 0);

    // random part
    for (i = 0; i < RANDOM_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 6) == 0) begin
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        z = $urandom_range(0, 15);
      end else begin
        x = hot_coord();
        y = hot_coord();
        z = hot_coord();
      end
      if (r < 35) begin
        id = $urandom_range(0, 99);
        if (id < 40) id = 0;
        else if (id < 85) id = $urandom_range(1, 7);
        else id = $urandom_range(0, 255);
        cell_wr(x, y, z, id);
      end else if (r < 50) begin
        id = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 7);
        type_wr(id, int'($urandom_range(0, 3) != 0), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (r < 95) begin
        queue_mesh(x, y, z);
      end else begin
        push_word(KIND_SPARE, x, y, z, $urandom_range(0, 255), $urandom_range(0, 1),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || s_tvalid) @(posedge clk);
    while (faces_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/vfcm_pkg.sv
rtl/core/vfcm_ram.sv
rtl/core/vfcm_type_table.sv
rtl/core/vfcm_seq.sv
rtl/core/vfcm_emit.sv
rtl/core/voxel_face_culling_mesher.sv
tb/sv/tb_voxel_face_culling_mesher.sv
